@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file lpp_check
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held
`define AST_CHK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds through reset
`define AST_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");

`endif

@@ rtl/core/lpp_pkg.sv @@
// ----------------------------------------------------------------------------
// lpp_pkg
// Widths, register indexes and reset values of the point projection block.
// ----------------------------------------------------------------------------
package lpp_pkg;

    localparam int CW  = 32;          // coordinate and coefficient width
    localparam int PW  = 64;          // product width
    localparam int HW  = 67;          // homogeneous sum width, Q35.32
    localparam int FB  = 16;          // fraction bits of the output
    localparam int NW  = HW + FB;     // shifted numerator width
    localparam int QW  = 32;          // quotient width
    localparam int DW  = HW + QW;     // divider compare width
    localparam int RW  = 64;          // configuration register width
    localparam int NREG = 6;
    localparam int IW  = 3;           // configuration index width

    localparam logic [IW-1:0] CFG_ROW0_A = 3'd0;
    localparam logic [IW-1:0] CFG_ROW0_B = 3'd1;
    localparam logic [IW-1:0] CFG_ROW1_A = 3'd2;
    localparam logic [IW-1:0] CFG_ROW1_B = 3'd3;
    localparam logic [IW-1:0] CFG_ROW2_A = 3'd4;
    localparam logic [IW-1:0] CFG_ROW2_B = 3'd5;

    localparam logic [RW-1:0] RST_ROW0_A = 64'h0000_0000_0001_0000;
    localparam logic [RW-1:0] RST_ROW0_B = 64'h0;
    localparam logic [RW-1:0] RST_ROW1_A = 64'h0001_0000_0000_0000;
    localparam logic [RW-1:0] RST_ROW1_B = 64'h0;
    localparam logic [RW-1:0] RST_ROW2_A = 64'h0;
    localparam logic [RW-1:0] RST_ROW2_B = 64'h0000_0000_0001_0000;

    localparam logic [QW-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [QW-1:0] SAT_NEG = 32'h8000_0000;

endpackage

@@ rtl/core/lidar_point_to_pixel_projection.sv @@
// ----------------------------------------------------------------------------
// lidar_point_to_pixel_projection
// Projects a lidar point through a 3x4 matrix and divides to pixel u, v.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall carry one point (x, y, z, Q16.16).
//   Output channel: o_valid / i_stall carry u, v (Q16.16) and two flags.
//   A transfer happens on a rising edge with valid high and stall low.
//   Configuration: i_cfg_we writes i_cfg_wdata into the coefficient
//   register at i_cfg_idx; indexes six and seven are dropped.
//   Steps from input transfer to the offered result: products, sums,
//   magnitudes, divider set-up, 32 quotient stages, sign and saturation.
//   Throughput: one point every cycle, except while stalled; the 32-stage
//   restoring divider, one quotient bit per stage, sets the depth.
//   Stall: the whole pipeline holds while the result register is full and
//   the receiver stalls; o_stall then rises in the same cycle.
//   Reset (synchronous, active low): valid bits clear and the matrix
//   returns to its identity-like defaults.
// ----------------------------------------------------------------------------
module lidar_point_to_pixel_projection
    import lpp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [IW-1:0]        i_cfg_idx,
    input  logic [RW-1:0]        i_cfg_wdata,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [CW-1:0] i_point_x,
    input  logic signed [CW-1:0] i_point_y,
    input  logic signed [CW-1:0] i_point_z,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [CW-1:0] o_pixel_u,
    output logic signed [CW-1:0] o_pixel_v,
    output logic                 o_zero_depth,
    output logic                 o_overflowed
);

    // coefficient registers
    logic [RW-1:0] r_coef [0:NREG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= RST_ROW0_A;
            r_coef[1] <= RST_ROW0_B;
            r_coef[2] <= RST_ROW1_A;
            r_coef[3] <= RST_ROW1_B;
            r_coef[4] <= RST_ROW2_A;
            r_coef[5] <= RST_ROW2_B;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROW0_A: r_coef[0] <= i_cfg_wdata;
                CFG_ROW0_B: r_coef[1] <= i_cfg_wdata;
                CFG_ROW1_A: r_coef[2] <= i_cfg_wdata;
                CFG_ROW1_B: r_coef[3] <= i_cfg_wdata;
                CFG_ROW2_A: r_coef[4] <= i_cfg_wdata;
                CFG_ROW2_B: r_coef[5] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // whole pipeline advances unless a held result is stalled
    logic r_ov;
    logic adv;
    assign adv     = !r_ov || !i_stall;
    assign o_stall = !adv;

    // ---------------- stage 1: nine products and the offset terms ----------
    logic              r_v1;
    logic signed [PW-1:0] r_prod [0:2][0:2];
    logic signed [PW-1:0] r_offs [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                r_prod[r][0] <= $signed(r_coef[2*r][CW-1:0]) * i_point_x;
                r_prod[r][1] <= $signed(r_coef[2*r][RW-1:CW]) * i_point_y;
                r_prod[r][2] <= $signed(r_coef[2*r+1][CW-1:0]) * i_point_z;
                // column 3 times 1.0 in Q32.32
                r_offs[r] <= PW'($signed({r_coef[2*r+1][RW-1:CW], 16'h0}));
            end
        end
    end

    // ---------------- stage 2: row sums ------------------------------------
    logic                 r_v2;
    logic signed [HW-1:0] r_h [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                r_h[r] <= HW'(r_prod[r][0]) + HW'(r_prod[r][1])
                        + HW'(r_prod[r][2]) + HW'(r_offs[r]);
            end
        end
    end

    // ---------------- stage 3: magnitudes and signs ------------------------
    logic          r_v3;
    logic [HW-1:0] r_na_u, r_na_v, r_da;
    logic          r_neg_u3, r_neg_v3, r_zero3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_na_u   <= r_h[0][HW-1] ? HW'(-r_h[0]) : HW'(r_h[0]);
            r_na_v   <= r_h[1][HW-1] ? HW'(-r_h[1]) : HW'(r_h[1]);
            r_da     <= r_h[2][HW-1] ? HW'(-r_h[2]) : HW'(r_h[2]);
            r_neg_u3 <= r_h[0][HW-1] ^ r_h[2][HW-1];
            r_neg_v3 <= r_h[1][HW-1] ^ r_h[2][HW-1];
            r_zero3  <= (r_h[2] == '0);
        end
    end

    // ---------------- stage 4 and divider chain ----------------------------
    // index 0 is the set-up stage; index s+1 holds the result of quotient bit
    // QW-1-s
    logic          r_dv   [0:QW];
    logic [NW-1:0] r_rem_u [0:QW];
    logic [NW-1:0] r_rem_v [0:QW];
    logic [QW-1:0] r_q_u  [0:QW];
    logic [QW-1:0] r_q_v  [0:QW];
    logic [HW-1:0] r_d    [0:QW];
    logic          r_neg_u [0:QW];
    logic          r_neg_v [0:QW];
    logic          r_big_u [0:QW];
    logic          r_big_v [0:QW];
    logic          r_zero  [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (adv) begin
            r_dv[0] <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // a quotient of 2^32 or more saturates whatever the sign
            r_big_u[0] <= {{FB{1'b0}}, r_na_u} >= {r_da, {FB{1'b0}}};
            r_big_v[0] <= {{FB{1'b0}}, r_na_v} >= {r_da, {FB{1'b0}}};
            r_rem_u[0] <= {r_na_u, {FB{1'b0}}};
            r_rem_v[0] <= {r_na_v, {FB{1'b0}}};
            r_q_u[0]   <= '0;
            r_q_v[0]   <= '0;
            r_d[0]     <= r_da;
            r_neg_u[0] <= r_neg_u3;
            r_neg_v[0] <= r_neg_v3;
            r_zero[0]  <= r_zero3;
        end
    end

    for (genvar s = 0; s < QW; s++) begin : g_div
        localparam int BIT = QW - 1 - s;
        logic [DW-1:0] dsh;
        logic [DW-1:0] ru, rv;
        logic          ge_u, ge_v;

        always_comb begin
            dsh  = DW'(r_d[s]) << BIT;
            ru   = DW'(r_rem_u[s]);
            rv   = DW'(r_rem_v[s]);
            ge_u = ru >= dsh;
            ge_v = rv >= dsh;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s+1] <= 1'b0;
            end else if (adv) begin
                r_dv[s+1] <= r_dv[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_rem_u[s+1] <= ge_u ? NW'(ru - dsh) : r_rem_u[s];
                r_rem_v[s+1] <= ge_v ? NW'(rv - dsh) : r_rem_v[s];
                r_q_u[s+1]   <= r_q_u[s] | (QW'(ge_u) << BIT);
                r_q_v[s+1]   <= r_q_v[s] | (QW'(ge_v) << BIT);
                r_d[s+1]     <= r_d[s];
                r_neg_u[s+1] <= r_neg_u[s];
                r_neg_v[s+1] <= r_neg_v[s];
                r_big_u[s+1] <= r_big_u[s];
                r_big_v[s+1] <= r_big_v[s];
                r_zero[s+1]  <= r_zero[s];
            end
        end
    end

    // ---------------- final stage: sign, saturation, result register ------
    logic [QW-1:0] fu, fv;
    logic          sat_u, sat_v;

    always_comb begin
        sat_u = 1'b0;
        sat_v = 1'b0;
        if (r_neg_u[QW]) begin
            sat_u = r_big_u[QW] || (r_q_u[QW] > SAT_NEG);
            fu    = sat_u ? SAT_NEG : QW'(-r_q_u[QW]);
        end else begin
            sat_u = r_big_u[QW] || (r_q_u[QW] > SAT_POS);
            fu    = sat_u ? SAT_POS : r_q_u[QW];
        end
        if (r_neg_v[QW]) begin
            sat_v = r_big_v[QW] || (r_q_v[QW] > SAT_NEG);
            fv    = sat_v ? SAT_NEG : QW'(-r_q_v[QW]);
        end else begin
            sat_v = r_big_v[QW] || (r_q_v[QW] > SAT_POS);
            fv    = sat_v ? SAT_POS : r_q_v[QW];
        end
    end

    logic [QW-1:0] r_u, r_vv;
    logic          r_zd, r_of;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_dv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // zero depth overrides the quotient
            r_u  <= r_zero[QW] ? '0 : fu;
            r_vv <= r_zero[QW] ? '0 : fv;
            r_zd <= r_zero[QW];
            r_of <= !r_zero[QW] && (sat_u || sat_v);
        end
    end

    assign o_valid      = r_ov;
    assign o_pixel_u    = r_u;
    assign o_pixel_v    = r_vv;
    assign o_zero_depth = r_zd;
    assign o_overflowed = r_of;

endmodule

@@ rtl/core/lpp_check.sv @@
// ----------------------------------------------------------------------------
// lpp_check
// Port-level checks of the point projection block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpp_check
    import lpp_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic                 o_stall,
    input logic signed [CW-1:0] o_pixel_u,
    input logic signed [CW-1:0] o_pixel_v,
    input logic                 o_zero_depth,
    input logic                 o_overflowed
);

    // either coordinate sitting at a rail of the Q16.16 range
    logic u_rail, v_rail;
    assign u_rail = (o_pixel_u == SAT_POS) || (o_pixel_u == SAT_NEG);
    assign v_rail = (o_pixel_v == SAT_POS) || (o_pixel_v == SAT_NEG);

    // a stalled result holds
    `AST_CHK(a_hold, o_valid && i_stall |=> o_valid && $stable(o_pixel_u) && $stable(o_pixel_v))

    // zero depth gives a clean zero result
    `AST_CHK(a_zero, o_valid && o_zero_depth |-> o_pixel_u == 0 && o_pixel_v == 0 && !o_overflowed)

    // an overflow leaves at least one coordinate at a rail
    `AST_CHK(a_sat, o_valid && o_overflowed |-> u_rail || v_rail)

    // input is stalled only while a result waits on a stalled receiver
    `AST_CHK(a_stall, o_stall |-> o_valid && i_stall)

    // reset empties the pipeline
    `AST_RST(a_rst, !i_rst_n |=> !o_valid)

endmodule

bind lidar_point_to_pixel_projection lpp_check u_lpp_check (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives lidar points into the projection block under a range of matrices,
// predicts u, v and both flags per transfer and checks them in order.
// ----------------------------------------------------------------------------
module testbench;
    import lpp_pkg::*;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_point;

    typedef struct {
        logic signed [CW-1:0] u;
        logic signed [CW-1:0] v;
        logic                 zd;
        logic                 ov;
    } t_pixel;

    // Stimulus and stimulus handshake signals, all known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [IW-1:0]        i_cfg_idx   = '0;
    logic [RW-1:0]        i_cfg_wdata = '0;
    logic                 i_valid     = 1'b0;
    logic signed [CW-1:0] i_point_x   = '0;
    logic signed [CW-1:0] i_point_y   = '0;
    logic signed [CW-1:0] i_point_z   = '0;
    logic                 i_stall     = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic signed [CW-1:0] o_pixel_u;
    logic signed [CW-1:0] o_pixel_v;
    logic                 o_zero_depth;
    logic                 o_overflowed;

    t_point      pending_points[$];
    t_pixel      expected_pixels[$];
    logic [RW-1:0] coef_mirror[NREG];
    logic        idle_on    = 1'b1;
    logic        hold_start = 1'b0;
    int          hold_left  = 0;
    int          mismatches = 0;

    lidar_point_to_pixel_projection DUT (.*);

    always #5 i_clk = ~i_clk;

    // Signed Q16.16 coefficient at (row, col), taken from the mirrored registers
    function automatic logic signed [CW-1:0] coef_at(int row, int col);
        logic [RW-1:0] reg_val;
        reg_val = coef_mirror[row * 2 + col / 2];
        return (col % 2) ? reg_val[63:32] : reg_val[31:0];
    endfunction

    // Homogeneous sums in Q32.32, then exact truncating divide into Q16.16
    function automatic t_pixel project_point(t_point p);
        logic signed [127:0] h[3];
        logic signed [127:0] c, quo;
        logic signed [127:0] pt[3];
        t_pixel r;
        pt[0] = p.x;
        pt[1] = p.y;
        pt[2] = p.z;
        for (int row = 0; row < 3; row++) begin
            c = coef_at(row, 3);
            h[row] = c * 128'sd65536;
            for (int k = 0; k < 3; k++) begin
                c = coef_at(row, k);
                h[row] = h[row] + c * pt[k];
            end
        end
        r = '{u: '0, v: '0, zd: 1'b0, ov: 1'b0};
        if (h[2] == 0) begin
            r.zd = 1'b1;
            return r;
        end
        for (int k = 0; k < 2; k++) begin
            quo = (h[k] <<< FB) / h[2];
            if (quo > 128'sd2147483647) begin
                quo   = SAT_POS;
                r.ov  = 1'b1;
            end else if (quo < -128'sd2147483648) begin
                quo   = $signed({1'b1, 31'b0});
                r.ov  = 1'b1;
            end
            if (k == 0) r.u = quo[31:0];
            else        r.v = quo[31:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [CW-1:0] got, logic [CW-1:0] want);
        mismatches++;
        $display("%0t mismatch on %s: got %h, expected %h", $time, field, got, want);
    endtask

    // Driver: advance to the next pending point once the current one transfers
    always @(posedge i_clk) begin : drive_points
        t_point p;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                p = '{x: i_point_x, y: i_point_y, z: i_point_z};
                expected_pixels = {expected_pixels, project_point(p)};
            end
            if (!i_valid || !o_stall) begin
                if (pending_points.size() > 0 && !(idle_on && $urandom_range(99) < 25)) begin
                    p = pending_points.pop_front();
                    i_valid   <= 1'b1;
                    i_point_x <= p.x;
                    i_point_y <= p.y;
                    i_point_z <= p.z;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted on its own
    always @(posedge i_clk) begin
        if (hold_start)
            hold_left <= 400;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : check_pixels
        t_pixel want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected result", o_pixel_u, '0);
            end else begin
                want = expected_pixels.pop_front();
                if (o_pixel_u !== want.u)    report_mismatch("pixel_u", o_pixel_u, want.u);
                if (o_pixel_v !== want.v)    report_mismatch("pixel_v", o_pixel_v, want.v);
                if (o_zero_depth !== want.zd)
                    report_mismatch("zero_depth", CW'(o_zero_depth), CW'(want.zd));
                if (o_overflowed !== want.ov)
                    report_mismatch("overflowed", CW'(o_overflowed), CW'(want.ov));
            end
        end
        i_stall <= (hold_left > 0) || (idle_on && $urandom_range(99) < 25);
    end

    task automatic write_coef(logic [IW-1:0] idx, logic [RW-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        if (idx < NREG) coef_mirror[idx] = val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One Q16.16 coefficient: full random, camera-like small, or an extreme
    function automatic logic [31:0] make_coef(int kind);
        case (kind)
            0: return $urandom;
            1: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
            default: begin
                case ($urandom_range(4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h0001_0000;
                    default: return 32'h0;
                endcase
            end
        endcase
    endfunction

    function automatic logic [31:0] make_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
            default: begin
                case ($urandom_range(4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h1;
                    default: return 32'h0;
                endcase
            end
        endcase
    endfunction

    task automatic push_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        pending_points = {pending_points, t_point'{x: x, y: y, z: z}};
    endtask

    task automatic push_random(int count);
        t_point p;
        for (int n = 0; n < count; n++) begin
            p.x = make_coord($urandom_range(2));
            p.y = make_coord($urandom_range(2));
            p.z = ($urandom_range(9) == 0) ? '0 : make_coord($urandom_range(2));
            pending_points = {pending_points, p};
        end
    endtask

    // Sender pause: hold until the block is empty, then let the pipe settle
    task automatic drain;
        while (pending_points.size() > 0 || i_valid || expected_pixels.size() > 0)
            @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    initial begin
        coef_mirror = '{RST_ROW0_A, RST_ROW0_B, RST_ROW1_A, RST_ROW1_B, RST_ROW2_A, RST_ROW2_B};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed points under the reset matrix: u = x / z, v = y / z
        push_point(0, 0, 0);
        push_point(32'h1234_0000, 32'h5, 0);
        push_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
        push_point(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
        push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_point(32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000);
        push_point(5, 7, 3);
        push_point(-5, 7, 3);
        push_point(32'h7FFF_FFFF, 0, 32'h0001_0000);
        push_point(32'h8000_0000, 0, 32'h0001_0000);
        push_point(32'h8000_0000, 0, 32'hFFFF_0000);
        push_point(32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF);
        drain();

        // Out-of-range indexes must leave the matrix alone
        write_coef(3'd6, {$urandom, $urandom});
        write_coef(3'd7, {$urandom, $urandom});
        push_random(20);
        drain();

        for (int phase = 0; phase < 9; phase++) begin
            int kind;
            kind = (phase == 8) ? 2 : phase % 3;
            for (int r = 0; r < NREG; r++)
                write_coef(r[IW-1:0], {make_coef(kind), make_coef(kind)});
            // Keep depth sane on odd-phase camera-like matrices so the quotients mean something
            if (kind == 1 && phase % 2 == 1)
                write_coef(CFG_ROW2_B, {32'h0, 32'h0001_0000});
            idle_on = (phase != 4);
            push_random(60);
            if (phase == 2) begin
                repeat (20) @(posedge i_clk);
                hold_start <= 1'b1;
                @(posedge i_clk);
                hold_start <= 1'b0;
            end
            drain();
        end

        // Extreme matrix last
        write_coef(CFG_ROW0_A, 64'h8000_0000_8000_0000);
        write_coef(CFG_ROW0_B, 64'h7FFF_FFFF_8000_0000);
        write_coef(CFG_ROW1_A, 64'h7FFF_FFFF_7FFF_FFFF);
        write_coef(CFG_ROW1_B, 64'hFFFF_FFFF_FFFF_FFFF);
        write_coef(CFG_ROW2_A, 64'h0000_0001_FFFF_FFFF);
        write_coef(CFG_ROW2_B, 64'h8000_0000_0000_0001);
        push_random(40);
        drain();

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
